// ===== src/rtsr_pkg.sv =====
// shared types, codes and constants for the remote tilt setpoint ramp
// used by every module of the block; depends on nothing
`default_nettype none

package rtsr_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] AGE_LIMIT_MS = 16'd1000;
  localparam logic [27:0] ALPHA_Q16    = 28'd1311;
  localparam logic [27:0] BETA_Q16     = 28'd64225;
  localparam logic [24:0] SNAP_WINDOW  = 25'd131072;
  localparam logic [16:0] IN_FULL      = 17'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_TYPE   = 3'd0,
    CFG_DEADBAND      = 3'd1,
    CFG_DEADBAND_GAIN = 3'd2,
    CFG_INVERT_INPUT  = 3'd3,
    CFG_ANGLE_LIMIT   = 3'd4,
    CFG_RAMP_RATE     = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_PPM  = 2'd1,
    SRC_JOY  = 2'd2
  } src_e;

  typedef struct packed {
    logic [1:0]  source_type;
    logic [13:0] deadband;
    logic [15:0] deadband_gain;
    logic        invert_input;
    logic [14:0] angle_limit;
    logic [15:0] ramp_rate;
  } cfg_t;

  // one conditioned request handed from front to back
  typedef struct packed {
    logic signed [15:0] held;
    logic               darkride;
    logic               conn;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_TGT,
    B_DIFF,
    B_ACC1,
    B_ACC2,
    B_ACC3,
    B_RAMP,
    B_UPD
  } back_state_e;

endpackage

`default_nettype wire

// ===== src/rtsr_if.sv =====
// valid/ready channel interfaces for input requests and result items
// standalone, no package needed
`default_nettype none

interface rtsr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] ppm_value;
  logic        [15:0] ppm_age_ms;
  logic signed [15:0] joystick_value;
  logic        [15:0] joystick_age_ms;
  logic               darkride;

  modport source (
    output valid, ppm_value, ppm_age_ms, joystick_value, joystick_age_ms, darkride,
    input  ready
  );
  modport sink (
    input  valid, ppm_value, ppm_age_ms, joystick_value, joystick_age_ms, darkride,
    output ready
  );
endinterface

interface rtsr_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] tilt_setpoint;
  logic signed [15:0] conditioned_input;
  logic               connected;

  modport source (
    output valid, tilt_setpoint, conditioned_input, connected,
    input  ready
  );
  modport sink (
    input  valid, tilt_setpoint, conditioned_input, connected,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/rtsr_front.sv =====
// front end: accepts requests, selects the source, checks freshness, applies deadband
// depends on rtsr_pkg and rtsr_in_if
`default_nettype none

module rtsr_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire rtsr_pkg::cfg_t cfg_i,
  rtsr_in_if.sink           in_if,
  output logic              push_valid_o,
  input  wire logic         push_ready_i,
  output rtsr_pkg::cmd_t    push_cmd_o
);
  import rtsr_pkg::*;

  logic               a_valid_q;
  logic signed [15:0] a_v_q, sel_v;
  logic               a_conn_q, sel_conn;
  logic               a_dark_q;
  logic               in_acc;

  logic signed [16:0] v_ext;
  logic        [16:0] mag, over;
  logic        [32:0] scaled;
  logic        [33:0] rounded;
  logic        [25:0] m;
  logic        [15:0] m_sat;
  logic signed [15:0] c;

  assign in_if.ready = !a_valid_q || push_ready_i;
  assign in_acc      = in_if.valid && in_if.ready;

  always_comb begin
    sel_v    = '0;
    sel_conn = 1'b0;
    case (cfg_i.source_type)
      SRC_PPM: begin
        sel_v    = in_if.ppm_value;
        sel_conn = in_if.ppm_age_ms < AGE_LIMIT_MS;
      end
      SRC_JOY: begin
        sel_v    = in_if.joystick_value;
        sel_conn = in_if.joystick_age_ms < AGE_LIMIT_MS;
      end
      default: begin
        sel_v    = '0;
        sel_conn = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_acc) begin
      a_valid_q <= 1'b1;
    end else if (push_ready_i) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_v_q    <= sel_v;
      a_conn_q <= sel_conn;
      a_dark_q <= in_if.darkride;
    end
  end

  // deadband: strip the band, rescale by the gain, clamp to full scale; zero when not connected, negated when inverted
  always_comb begin
    v_ext   = 17'(a_v_q);
    mag     = v_ext[16] ? 17'(-v_ext) : 17'(v_ext);
    over    = mag - {3'b0, cfg_i.deadband};
    scaled  = over * cfg_i.deadband_gain;
    rounded = {1'b0, scaled} + 34'd128;
    m       = rounded[33:8];
    m_sat   = (m > 26'(IN_FULL)) ? 16'(IN_FULL) : m[15:0];
    if (!a_conn_q || mag < {3'b0, cfg_i.deadband}) begin
      c = '0;
    end else begin
      c = v_ext[16] ? -signed'(m_sat) : signed'(m_sat);
    end
    if (cfg_i.invert_input && a_conn_q) begin
      c = -c;
    end
  end

  assign push_valid_o        = a_valid_q;
  assign push_cmd_o.held     = c;
  assign push_cmd_o.darkride = a_dark_q;
  assign push_cmd_o.conn     = a_conn_q;

endmodule

`default_nettype wire

// ===== src/rtsr_queue.sv =====
// short register queue of conditioned requests between front and back
// depends on rtsr_pkg for the request type
`default_nettype none

module rtsr_queue #(
  parameter int unsigned Depth = rtsr_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire rtsr_pkg::cmd_t push_cmd_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output rtsr_pkg::cmd_t      pop_cmd_o
);
  import rtsr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = count_q != FullCnt;
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/rtsr_back.sv =====
// back end: target angle, smoothed slew step and setpoint update on one shared multiplier
// depends on rtsr_pkg and rtsr_out_if
`default_nettype none

module rtsr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rtsr_pkg::cfg_t cfg_i,
  input  wire logic           pop_valid_i,
  output logic                pop_ready_o,
  input  wire rtsr_pkg::cmd_t pop_cmd_i,
  rtsr_out_if.source          out_if
);
  import rtsr_pkg::*;

  function automatic logic signed [23:0] sat24(input logic signed [26:0] x);
    logic signed [26:0] hi, lo;
    hi = 27'sd8388607;
    lo = -27'sd8388608;
    if (x > hi) begin
      return 24'sd8388607;
    end else if (x < lo) begin
      return -24'sd8388608;
    end else begin
      return 24'(x);
    end
  endfunction

  back_state_e        state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic signed [23:0] sp_q, sp_d;
  logic signed [23:0] ramped_q, ramped_d;
  logic signed [23:0] target_q, target_d;
  logic signed [24:0] diff_q, diff_d;
  logic        [24:0] diff_abs;
  logic               near_q, near_d;
  logic        [26:0] astep_q, astep_d;
  logic signed [57:0] acc_q, acc_d;
  logic        [16:0] lin_q, lin_d;
  logic signed [52:0] prod_q, prod_d;
  logic signed [27:0] mul_a;
  logic signed [24:0] mul_b;
  logic               out_valid_q, out_valid_d;
  logic signed [23:0] out_sp_q, out_sp_d;
  logic signed [15:0] out_ci_q, out_ci_d;
  logic               out_conn_q, out_conn_d;
  logic               out_free;

  logic signed [52:0] tsum;
  logic signed [23:0] t_raw;
  logic signed [27:0] alpha_far;
  logic signed [58:0] rsum;
  logic signed [52:0] lsum;
  logic        [24:0] ramp_abs, cs_mag;
  logic signed [24:0] cs;

  assign out_free = !out_valid_q || out_if.ready;
  assign diff_abs = diff_q[24] ? 25'(-diff_q) : 25'(diff_q);
  assign prod_d   = mul_a * mul_b;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    sp_d        = sp_q;
    ramped_d    = ramped_q;
    target_d    = target_q;
    diff_d      = diff_q;
    near_d      = near_q;
    astep_d     = astep_q;
    acc_d       = acc_q;
    lin_d       = lin_q;
    out_valid_d = out_valid_q && !out_if.ready;
    out_sp_d    = out_sp_q;
    out_ci_d    = out_ci_q;
    out_conn_d  = out_conn_q;
    pop_ready_o = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    tsum        = prod_q + 53'sd32;
    t_raw       = 24'(tsum >>> 6);
    alpha_far   = '0;
    rsum        = '0;
    lsum        = prod_q + 53'sd65536;
    ramp_abs    = ramped_q[23] ? 25'(-25'(ramped_q)) : 25'(ramped_q);
    cs_mag      = (ramp_abs < {8'b0, lin_q}) ? ramp_abs : {8'b0, lin_q};
    cs          = diff_q[24] ? -signed'(cs_mag) :
                  ((diff_q == '0) ? '0 : signed'(cs_mag));

    case (state_q)
      B_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          cmd_d   = pop_cmd_i;
          state_d = B_TGT;
        end
      end
      B_TGT: begin
        mul_a   = 28'(cmd_q.held);
        mul_b   = signed'({10'b0, cfg_i.angle_limit});
        state_d = B_DIFF;
      end
      B_DIFF: begin
        target_d = cmd_q.darkride ? -t_raw : t_raw;
        diff_d   = 25'(target_d) - 25'(sp_q);
        near_d   = (diff_d[24] ? 25'(-diff_d) : 25'(diff_d)) < SNAP_WINDOW;
        mul_a    = signed'(ALPHA_Q16);
        mul_b    = signed'({9'b0, cfg_i.ramp_rate});
        state_d  = B_ACC1;
      end
      B_ACC1: begin
        astep_d = prod_q[26:0];
        mul_a   = signed'(BETA_Q16);
        mul_b   = 25'(ramped_q);
        state_d = B_ACC2;
      end
      B_ACC2: begin
        // far from target the step only sees the sign of the error
        if (diff_q[24]) begin
          alpha_far = -signed'({1'b0, astep_q});
        end else if (diff_q != '0) begin
          alpha_far = signed'({1'b0, astep_q});
        end
        if (near_q) begin
          acc_d = {prod_q[40:0], 17'b0};
        end else begin
          acc_d = 58'(prod_q) + 58'(alpha_far);
        end
        mul_a   = signed'({1'b0, astep_q});
        mul_b   = diff_q;
        state_d = B_ACC3;
      end
      B_ACC3: begin
        if (near_q) begin
          acc_d = acc_q + 58'(prod_q);
        end
        mul_a   = signed'({3'b0, diff_abs});
        mul_b   = signed'({9'b0, cfg_i.ramp_rate});
        state_d = B_RAMP;
      end
      B_RAMP: begin
        lin_d = 17'(lsum >>> 17);
        if (near_q) begin
          rsum     = 59'(acc_q) + (59'sd1 <<< 32);
          ramped_d = sat24(27'(rsum >>> 33));
        end else begin
          rsum     = 59'(acc_q) + 59'sd32768;
          ramped_d = sat24(27'(rsum >>> 16));
        end
        state_d = B_UPD;
      end
      B_UPD: begin
        if (out_free) begin
          if (!near_q) begin
            sp_d = sat24(27'(sp_q) + 27'(ramped_q));
          end else if (diff_abs < cs_mag) begin
            sp_d = target_q;
          end else begin
            sp_d = sat24(27'(sp_q) + 27'(cs));
          end
          out_valid_d = 1'b1;
          out_sp_d    = sp_d;
          out_ci_d    = cmd_q.held;
          out_conn_d  = cmd_q.conn;
          state_d     = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      sp_q        <= '0;
      ramped_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      ramped_q    <= ramped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    target_q   <= target_d;
    diff_q     <= diff_d;
    near_q     <= near_d;
    astep_q    <= astep_d;
    acc_q      <= acc_d;
    lin_q      <= lin_d;
    prod_q     <= prod_d;
    out_sp_q   <= out_sp_d;
    out_ci_q   <= out_ci_d;
    out_conn_q <= out_conn_d;
  end

  assign out_if.valid             = out_valid_q;
  assign out_if.tilt_setpoint     = out_sp_q;
  assign out_if.conditioned_input = out_ci_q;
  assign out_if.connected         = out_conn_q;

endmodule

`default_nettype wire

// ===== src/remote_tilt_setpoint_ramp_core.sv =====
// the back sequencer takes one request at a time and runs all
//   five multiplies of a tick through its single shared multiplier before it takes the next
// the front and the queue keep accepting while the queue has room, while the back works or the result waits
// reset: asynchronous active low; setpoint, slew step and queue clear, config to defaults
// depends on rtsr_pkg, rtsr_if, rtsr_front, rtsr_queue and rtsr_back
`default_nettype none

module remote_tilt_setpoint_ramp_core #(
  parameter int unsigned QueueDepth = rtsr_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rtsr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rtsr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  rtsr_in_if.sink                             in_if,
  rtsr_out_if.source                          out_if
);
  import rtsr_pkg::*;

  cfg_t cfg_q;
  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_type   <= '0;
      cfg_q.deadband      <= '0;
      cfg_q.deadband_gain <= 16'd256;
      cfg_q.invert_input  <= 1'b0;
      cfg_q.angle_limit   <= '0;
      cfg_q.ramp_rate     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SOURCE_TYPE:   cfg_q.source_type   <= cfg_wdata_i[1:0];
        CFG_DEADBAND:      cfg_q.deadband      <= cfg_wdata_i[13:0];
        CFG_DEADBAND_GAIN: cfg_q.deadband_gain <= cfg_wdata_i;
        CFG_INVERT_INPUT:  cfg_q.invert_input  <= cfg_wdata_i[0];
        CFG_ANGLE_LIMIT:   cfg_q.angle_limit   <= cfg_wdata_i[14:0];
        CFG_RAMP_RATE:     cfg_q.ramp_rate     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  rtsr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_if        (in_if),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  rtsr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  rtsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_if      (out_if)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// testbench for remote_tilt_setpoint_ramp_core: directed, stall and random tick sequences
// checks each result against a cycle-free model of conditioning and slew ramp
// depends on rtsr_pkg, rtsr_if and the core
module tb;
  import rtsr_pkg::*;

  localparam longint SmoothQ16   = longint'(ALPHA_Q16);
  localparam longint KeepQ16     = longint'(BETA_Q16);
  localparam longint SnapDeg     = longint'(SNAP_WINDOW);
  localparam longint InFull      = longint'(IN_FULL);
  localparam longint S24Max      = 64'sd8388607;
  localparam longint S24Min      = -64'sd8388608;
  localparam int     CycleLimit  = 400000;
  localparam int     PhaseCount  = 12;
  localparam int     PhaseTicks  = 150;

  typedef struct {
    logic signed [15:0] ppm_value;
    logic        [15:0] ppm_age;
    logic signed [15:0] joy_value;
    logic        [15:0] joy_age;
    logic               darkride;
  } tick_t;

  typedef struct {
    logic signed [23:0] tilt;
    logic signed [15:0] cond;
    logic               conn;
  } ramp_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  rtsr_in_if  in_if ();
  rtsr_out_if out_if ();

  remote_tilt_setpoint_ramp_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  // model state
  cfg_t   model_cfg;
  longint held_input;
  longint setpoint;
  longint slew_step;

  ramp_result_t pending_setpoints[$];
  int           mismatch_cnt;
  int           cycle_cnt;
  int           hold_req;
  bit           src_idle;
  bit           sink_idle;
  bit           offering;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint round_shr(input longint x, input int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint mag_of(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint sign_of(input longint x);
    return (x > 0) ? 64'sd1 : ((x < 0) ? -64'sd1 : 64'sd0);
  endfunction

  function automatic longint clip24(input longint x);
    return (x < S24Min) ? S24Min : ((x > S24Max) ? S24Max : x);
  endfunction

  // one control tick: condition the sample, then slew the setpoint
  function automatic ramp_result_t compute_setpoint(input tick_t t);
    longint v, mag, db, gain, lim, step, m, c, target, diff, adiff, acc, lin, cs;
    bit conn;
    ramp_result_t r;
    v    = 0;
    conn = 1'b0;
    db   = model_cfg.deadband;
    gain = model_cfg.deadband_gain;
    lim  = model_cfg.angle_limit;
    step = model_cfg.ramp_rate;
    case (model_cfg.source_type)
      SRC_PPM: begin
        v    = t.ppm_value;
        conn = t.ppm_age < AGE_LIMIT_MS;
      end
      SRC_JOY: begin
        v    = t.joy_value;
        conn = t.joy_age < AGE_LIMIT_MS;
      end
      default: ;
    endcase
    if (!conn) begin
      held_input = 0;
    end else begin
      mag = mag_of(v);
      if (mag < db) begin
        c = 0;
      end else begin
        m = round_shr((mag - db) * gain, 8);
        if (m > InFull) m = InFull;
        c = sign_of(v) * m;
      end
      if (model_cfg.invert_input) c = -c;
      held_input = c;
    end
    target = round_shr(held_input * lim, 6);
    if (t.darkride) target = -target;
    diff  = target - setpoint;
    adiff = mag_of(diff);
    if (adiff < SnapDeg) begin
      acc       = SmoothQ16 * step * diff + KeepQ16 * slew_step * 64'sd131072;
      slew_step = clip24(round_shr(acc, 33));
      lin       = round_shr(adiff * step, 17);
      cs        = mag_of(slew_step);
      if (lin < cs) cs = lin;
      cs = cs * sign_of(diff);
      // snap once the step would carry past the target
      if (adiff < mag_of(cs)) setpoint = target;
      else setpoint = clip24(setpoint + cs);
    end else begin
      acc       = SmoothQ16 * step * sign_of(diff) + KeepQ16 * slew_step;
      slew_step = clip24(round_shr(acc, 16));
      setpoint  = clip24(setpoint + slew_step);
    end
    r.tilt = setpoint[23:0];
    r.cond = held_input[15:0];
    r.conn = conn;
    return r;
  endfunction

  task automatic send_tick(input tick_t t);
    int gap;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      if (offering) in_if.valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.ppm_value       <= t.ppm_value;
    in_if.ppm_age_ms      <= t.ppm_age;
    in_if.joystick_value  <= t.joy_value;
    in_if.joystick_age_ms <= t.joy_age;
    in_if.darkride        <= t.darkride;
    offering = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_setpoints.push_back(compute_setpoint(t));
  endtask

  function automatic tick_t mk_tick(input logic signed [15:0] pv, input logic [15:0] pa,
                                    input logic signed [15:0] jv, input logic [15:0] ja,
                                    input logic dark);
    tick_t t;
    t.ppm_value = pv;
    t.ppm_age   = pa;
    t.joy_value = jv;
    t.joy_age   = ja;
    t.darkride  = dark;
    return t;
  endfunction

  task automatic wait_all_results();
    if (offering) in_if.valid <= 1'b0;
    offering = 1'b0;
    while (pending_setpoints.size() != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // drains the block first, so the registers are written only while it is idle
  task automatic load_config(input cfg_t c);
    wait_all_results();
    put_reg(CFG_SOURCE_TYPE, CFG_DATA_W'(c.source_type));
    put_reg(CFG_DEADBAND, CFG_DATA_W'(c.deadband));
    put_reg(CFG_DEADBAND_GAIN, c.deadband_gain);
    put_reg(CFG_INVERT_INPUT, CFG_DATA_W'(c.invert_input));
    put_reg(CFG_ANGLE_LIMIT, CFG_DATA_W'(c.angle_limit));
    put_reg(CFG_RAMP_RATE, c.ramp_rate);
    cfg_we_i <= 1'b0;
    model_cfg = c;
  endtask

  function automatic cfg_t mk_cfg(input logic [1:0] src, input logic [13:0] db,
                                  input logic [15:0] gain, input logic inv,
                                  input logic [14:0] lim, input logic [15:0] rate);
    cfg_t c;
    c.source_type   = src;
    c.deadband      = db;
    c.deadband_gain = gain;
    c.invert_input  = inv;
    c.angle_limit   = lim;
    c.ramp_rate     = rate;
    return c;
  endfunction

  function automatic cfg_t pick_config();
    cfg_t c;
    int g;
    c.source_type = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) :
                                                  2'($urandom_range(1, 2));
    case ($urandom_range(0, 3))
      0: c.deadband = 14'd0;
      1: c.deadband = 14'd16383;
      2: c.deadband = 14'($urandom_range(0, 2000));
      default: c.deadband = 14'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: c.deadband_gain = 16'd256;
      1: c.deadband_gain = 16'hFFFF;
      2: c.deadband_gain = 16'($urandom_range(0, 255));
      3: c.deadband_gain = 16'($urandom);
      default: begin
        g = (256 * 16384) / (16384 - int'(c.deadband));
        c.deadband_gain = (g > 65535) ? 16'hFFFF : 16'(g);
      end
    endcase
    c.invert_input = 1'($urandom);
    case ($urandom_range(0, 3))
      0: c.angle_limit = 15'h7FFF;
      1: c.angle_limit = 15'd0;
      2: c.angle_limit = 15'($urandom_range(0, 1024));
      default: c.angle_limit = 15'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: c.ramp_rate = 16'hFFFF;
      1: c.ramp_rate = 16'd0;
      2: c.ramp_rate = 16'($urandom_range(0, 4096));
      default: c.ramp_rate = 16'($urandom);
    endcase
    return c;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    int s;
    case ($urandom_range(0, 6))
      0: s = 16384;
      1: s = -16384;
      2: s = int'($urandom_range(0, 65535));
      3: s = int'($urandom_range(0, 32768)) - 16384;
      4: begin
        s = int'(model_cfg.deadband) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1)) s = -s;
      end
      5: s = int'($urandom_range(0, 64)) - 32;
      default: s = 0;
    endcase
    return s[15:0];
  endfunction

  function automatic logic [15:0] pick_age(input bit fresh);
    if (fresh) return ($urandom_range(0, 15) == 0) ? 16'd999 : 16'($urandom_range(0, 999));
    case ($urandom_range(0, 3))
      0: return 16'd1000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  // runs of steady samples let the setpoint settle and reach the snap window
  task automatic run_segments(input int count);
    tick_t base, t;
    int sent, run_len;
    sent = 0;
    while (sent < count) begin
      base     = mk_tick(pick_sample(), 16'd0, pick_sample(), 16'd0, 1'($urandom));
      run_len  = $urandom_range(1, 60);
      for (int k = 0; k < run_len && sent < count; k++) begin
        if ($urandom_range(0, 99) < 85) begin
          t = base;
          if ($urandom_range(0, 9) == 0) begin
            t.ppm_value = base.ppm_value + 16'($urandom_range(0, 6)) - 16'sd3;
            t.joy_value = base.joy_value + 16'($urandom_range(0, 6)) - 16'sd3;
          end
          t.ppm_age = pick_age(1'b1);
          t.joy_age = pick_age(1'b1);
          if ($urandom_range(0, 49) == 0) t.darkride = ~base.darkride;
        end else begin
          t = mk_tick(16'($urandom), pick_age($urandom_range(0, 1)),
                      16'($urandom), pick_age($urandom_range(0, 1)), 1'($urandom));
        end
        send_tick(t);
        sent++;
      end
    end
  endtask

  task automatic test_directed();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    // reset defaults: no source selected
    send_tick(mk_tick(16'sd16384, 16'd0, -16'sd16384, 16'd0, 1'b0));
    send_tick(mk_tick(16'sh7FFF, 16'd5, 16'sh7FFF, 16'd5, 1'b1));
    load_config(mk_cfg(SRC_PPM, 14'd0, 16'd256, 1'b0, 15'h7FFF, 16'hFFFF));
    send_tick(mk_tick(16'sd16384, 16'd0, 16'sd0, 16'd0, 1'b0));
    send_tick(mk_tick(-16'sd16384, 16'd999, 16'sd0, 16'd0, 1'b0));
    send_tick(mk_tick(16'sh7FFF, 16'd0, 16'sd0, 16'hFFFF, 1'b0));
    send_tick(mk_tick(16'sh8000, 16'd0, 16'sd0, 16'd0, 1'b0));
    send_tick(mk_tick(16'sd16384, 16'd1000, 16'sd16384, 16'd0, 1'b0));
    send_tick(mk_tick(16'sd16384, 16'hFFFF, 16'sd0, 16'd0, 1'b0));
    send_tick(mk_tick(16'sd16384, 16'd0, 16'sd0, 16'd0, 1'b1));
    // joystick, wide deadband, inverted, one degree limit
    load_config(mk_cfg(SRC_JOY, 14'd8192, 16'd512, 1'b1, 15'd256, 16'hFFFF));
    send_tick(mk_tick(16'sd0, 16'hFFFF, 16'sd8191, 16'd0, 1'b0));
    send_tick(mk_tick(16'sd0, 16'hFFFF, 16'sd8192, 16'd0, 1'b0));
    send_tick(mk_tick(16'sd0, 16'hFFFF, 16'sd16384, 16'd10, 1'b0));
    send_tick(mk_tick(16'sd0, 16'hFFFF, -16'sd12000, 16'd999, 1'b1));
    send_tick(mk_tick(16'sd16384, 16'd0, 16'sd16384, 16'd1000, 1'b0));
    // unused source code, gain below unity
    load_config(mk_cfg(2'd3, 14'd100, 16'd100, 1'b0, 15'd1000, 16'd3000));
    send_tick(mk_tick(16'sd16384, 16'd0, 16'sd16384, 16'd0, 1'b0));
    send_tick(mk_tick(-16'sd500, 16'd0, 16'sd500, 16'd0, 1'b1));
    // full deadband, max gain, zero limit and rate
    load_config(mk_cfg(SRC_PPM, 14'd16383, 16'hFFFF, 1'b1, 15'd0, 16'd0));
    send_tick(mk_tick(16'sd16384, 16'd0, 16'sd0, 16'd0, 1'b0));
    send_tick(mk_tick(-16'sd16384, 16'd0, 16'sd0, 16'd0, 1'b1));
  endtask

  task automatic test_backpressure();
    load_config(mk_cfg(SRC_PPM, 14'd500, 16'd264, 1'b0, 15'd4000, 16'd20000));
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_req  = 300;
    run_segments(40);
    // sender pauses until the block has drained
    wait_all_results();
  endtask

  task automatic test_random();
    cfg_t c;
    for (int p = 0; p < PhaseCount; p++) begin
      c = pick_config();
      if (p == 0) c = mk_cfg(SRC_JOY, 14'd0, 16'd256, 1'b0, 15'h7FFF, 16'hFFFF);
      load_config(c);
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      run_segments(PhaseTicks);
    end
  endtask

  // result sink with per-result stalls and one long hold on request
  initial begin : drive_sink
    int wait_cyc;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req > 0) begin
        wait_cyc = hold_req;
        hold_req = 0;
      end else begin
        wait_cyc = sink_idle ? $urandom_range(0, 9) : 0;
      end
      if (wait_cyc > 0) begin
        out_if.ready <= 1'b0;
        repeat (wait_cyc) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    ramp_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_setpoints.size() == 0) begin
        $error("result with no pending request: tilt_setpoint %0d", out_if.tilt_setpoint);
        mismatch_cnt++;
      end else begin
        want = pending_setpoints.pop_front();
        if (out_if.tilt_setpoint !== want.tilt) begin
          $error("tilt_setpoint: expected %0d, got %0d", want.tilt, out_if.tilt_setpoint);
          mismatch_cnt++;
        end
        if (out_if.conditioned_input !== want.cond) begin
          $error("conditioned_input: expected %0d, got %0d", want.cond,
                 out_if.conditioned_input);
          mismatch_cnt++;
        end
        if (out_if.connected !== want.conn) begin
          $error("connected: expected %0d, got %0d", want.conn, out_if.connected);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : run_tests
    mismatch_cnt = 0;
    hold_req     = 0;
    offering     = 1'b0;
    src_idle     = 1'b0;
    sink_idle    = 1'b0;
    model_cfg    = mk_cfg(SRC_NONE, 14'd0, 16'd256, 1'b0, 15'd0, 16'd0);
    held_input   = 0;
    setpoint     = 0;
    slew_step    = 0;
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= CFG_SOURCE_TYPE;
    cfg_wdata_i           <= '0;
    in_if.valid           <= 1'b0;
    in_if.ppm_value       <= '0;
    in_if.ppm_age_ms      <= '0;
    in_if.joystick_value  <= '0;
    in_if.joystick_age_ms <= '0;
    in_if.darkride        <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    wait_all_results();
    // wait for any stray result
    repeat (30) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_setpoints.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
